>>> rtl/wsst_pkg.sv
`timescale 1ns / 1ps

package wsst_pkg;

    // Width and ceiling of the running weight total.
    localparam int TOTAL_W = 48;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Item action codes.
    localparam logic ACT_EVAL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sweep;     // clear one present flag during the post-reset pass
        logic accept;    // latch the item and look up its variable
        logic slot_rd;   // read the dense slot of the variable
        logic exec;      // decide, write the memories, remove old weight
        logic add;       // add new weight to the total
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
    } t_stat;

endpackage

>>> rtl/wsst_ram.sv
`timescale 1ns / 1ps

module wsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wsst_ctrl.sv
`timescale 1ns / 1ps

module wsst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output wsst_pkg::t_cmd  o_cmd,
    input  wsst_pkg::t_stat i_stat
);
    import wsst_pkg::*;

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_SLOT = 6'b000100,
        S_EXEC = 6'b001000,
        S_ADD  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    // The output register can take a result when empty or being emptied.
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencing of one item through the datapath.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT: begin
                cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_SLOT;
                end
            end
            S_SLOT: begin
                cmd.slot_rd = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_ADD;
            end
            S_ADD: begin
                cmd.add = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Output valid flag follows loads and takes.
    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> rtl/wsst_dp.sv
`timescale 1ns / 1ps

module wsst_dp #(
    parameter int MAX_VARS    = 1024,
    parameter int WEIGHT_BITS = 32,
    localparam int VAR_W = $clog2(MAX_VARS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wsst_pkg::t_cmd                 i_cmd,
    output wsst_pkg::t_stat                o_stat,
    input  logic                           i_action,
    input  logic [VAR_W-1:0]               i_var_index,
    input  logic [WEIGHT_BITS-1:0]         i_unsat_weight,
    input  logic [WEIGHT_BITS-1:0]         i_critical_weight,
    output logic                           o_in_set,
    output logic [WEIGHT_BITS-1:0]         o_member_weight,
    output logic [VAR_W-1:0]               o_member_count,
    output logic [wsst_pkg::TOTAL_W-1:0]   o_total_weight
);
    import wsst_pkg::*;

    localparam int SLOT_W = $clog2(MAX_VARS);
    localparam logic [VAR_W-1:0] MAX_CNT = VAR_W'(MAX_VARS);

    // Latched item.
    logic                   r_act;
    logic [VAR_W-1:0]       r_var;
    logic                   r_var_ok;
    logic [WEIGHT_BITS-1:0] r_diff;
    logic                   r_diff_pos;

    // Lookup results.
    logic                   r_pres;
    logic [SLOT_W-1:0]      r_pos;
    logic [VAR_W-1:0]       r_last_var;
    logic [WEIGHT_BITS-1:0] r_last_wt;

    // Set state and per-item results.
    logic [VAR_W-1:0]       r_count, n_count;
    logic [TOTAL_W-1:0]     r_total, n_total;
    logic [VAR_W-1:0]       r_sweep;
    logic [WEIGHT_BITS-1:0] r_add_w;
    logic                   r_res_in;
    logic [WEIGHT_BITS-1:0] r_res_w;

    // Output register.
    logic                   r_o_in_set;
    logic [WEIGHT_BITS-1:0] r_o_weight;
    logic [VAR_W-1:0]       r_o_count;
    logic [TOTAL_W-1:0]     r_o_total;

    // Memory ports.
    logic                   pos_we, pres_we, list_we, wt_we, lst_re;
    logic [VAR_W-1:0]       pos_waddr, pres_waddr, var_raddr;
    logic [SLOT_W-1:0]      pos_wdata, pos_rdata;
    logic                   pres_wdata, pres_rdata;
    logic [SLOT_W-1:0]      list_waddr, wt_waddr, lst_raddr;
    logic [VAR_W-1:0]       list_wdata, list_rdata;
    logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;

    // Decode signals.
    logic [WEIGHT_BITS:0]   diff_ext;
    logic                   idx_ok;
    logic [VAR_W-1:0]       cnt_dec;
    logic [SLOT_W-1:0]      last_slot, app_slot, slot_addr;
    logic                   ev, member, do_put, do_upd, do_app, do_rem, do_move;
    logic [WEIGHT_BITS-1:0] sub_w;
    logic [TOTAL_W:0]       sub_ext, add_ext;

    // Difference of the two literal weights and range check of the index.
    assign diff_ext = {1'b0, i_unsat_weight} - {1'b0, i_critical_weight};
    assign idx_ok   = (i_var_index != '0) && (i_var_index <= MAX_CNT);
    assign var_raddr = idx_ok ? i_var_index : '0;

    // Slot of the last member, and the slot an appended member takes.
    assign cnt_dec   = r_count - VAR_W'(1);
    assign last_slot = cnt_dec[SLOT_W-1:0];
    assign app_slot  = r_count[SLOT_W-1:0];
    assign slot_addr = pres_rdata ? pos_rdata : '0;

    // A variable is a member when its slot lies below the count and points back to it.
    assign ev      = (r_act == ACT_EVAL) && r_var_ok;
    assign member  = ev && r_pres && (VAR_W'(r_pos) < r_count) && (list_rdata == r_var);
    assign do_put  = ev && r_diff_pos;
    assign do_upd  = do_put && member;
    assign do_app  = do_put && !member && (r_count < MAX_CNT);
    assign do_rem  = ev && !r_diff_pos && member;
    assign do_move = do_rem && (r_pos != last_slot);
    assign sub_w   = (do_upd || do_rem) ? wt_rdata : '0;

    // Total arithmetic: subtraction floors at zero, addition saturates.
    assign sub_ext = {1'b0, r_total} - {1'b0, TOTAL_W'(sub_w)};
    assign add_ext = {1'b0, r_total} + {1'b0, TOTAL_W'(r_add_w)};

    // Count and total updates.
    always_comb begin
        n_count = r_count;
        n_total = r_total;
        if (i_cmd.exec) begin
            if (r_act == ACT_CLEAR) begin
                n_count = '0;
                n_total = '0;
            end else begin
                if (do_app) begin
                    n_count = r_count + VAR_W'(1);
                end else if (do_rem) begin
                    n_count = cnt_dec;
                end
                n_total = sub_ext[TOTAL_W] ? '0 : sub_ext[TOTAL_W-1:0];
            end
        end else if (i_cmd.add) begin
            n_total = add_ext[TOTAL_W] ? TOTAL_MAX : add_ext[TOTAL_W-1:0];
        end
    end

    // Memory write steering.
    assign pos_we     = i_cmd.exec && (do_app || do_move);
    assign pos_waddr  = do_app ? r_var : r_last_var;
    assign pos_wdata  = do_app ? app_slot : r_pos;
    assign list_we    = i_cmd.exec && (do_app || do_move);
    assign list_waddr = do_app ? app_slot : r_pos;
    assign list_wdata = do_app ? r_var : r_last_var;
    assign wt_we      = i_cmd.exec && (do_app || do_upd || do_move);
    assign wt_waddr   = do_app ? app_slot : r_pos;
    assign wt_wdata   = do_move ? r_last_wt : r_diff;
    assign pres_we    = i_cmd.sweep || (i_cmd.exec && do_app);
    assign pres_waddr = i_cmd.sweep ? r_sweep : r_var;
    assign pres_wdata = !i_cmd.sweep;

    // Dense arrays are read at the last slot on accept, then at the variable's slot.
    assign lst_re    = i_cmd.accept || i_cmd.slot_rd;
    assign lst_raddr = i_cmd.slot_rd ? slot_addr : last_slot;

    wsst_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_VARS + 1)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (var_raddr),
        .o_rdata (pos_rdata)
    );

    wsst_ram #(.WIDTH(1), .DEPTH(MAX_VARS + 1)) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_waddr),
        .i_wdata (pres_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (var_raddr),
        .o_rdata (pres_rdata)
    );

    wsst_ram #(.WIDTH(VAR_W), .DEPTH(MAX_VARS)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_re    (lst_re),
        .i_raddr (lst_raddr),
        .o_rdata (list_rdata)
    );

    wsst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VARS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_re    (lst_re),
        .i_raddr (lst_raddr),
        .o_rdata (wt_rdata)
    );

    assign o_stat.sweep_done = (r_sweep == MAX_CNT);

    // Control state: count, total and the clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_sweep <= '0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
            if (i_cmd.sweep && (r_sweep != MAX_CNT)) begin
                r_sweep <= r_sweep + VAR_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act      <= i_action;
            r_var      <= i_var_index;
            r_var_ok   <= idx_ok;
            r_diff     <= diff_ext[WEIGHT_BITS-1:0];
            r_diff_pos <= !diff_ext[WEIGHT_BITS] && (diff_ext[WEIGHT_BITS-1:0] != '0);
        end
        if (i_cmd.slot_rd) begin
            r_pres     <= pres_rdata;
            r_pos      <= pos_rdata;
            r_last_var <= list_rdata;
            r_last_wt  <= wt_rdata;
        end
        if (i_cmd.exec) begin
            r_add_w  <= (do_upd || do_app) ? r_diff : '0;
            r_res_in <= do_upd || do_app;
            r_res_w  <= (do_upd || do_app) ? r_diff : '0;
        end
        if (i_cmd.load_out) begin
            r_o_in_set <= r_res_in;
            r_o_weight <= r_res_w;
            r_o_count  <= r_count;
            r_o_total  <= r_total;
        end
    end

    assign o_in_set        = r_o_in_set;
    assign o_member_weight = r_o_weight;
    assign o_member_count  = r_o_count;
    assign o_total_weight  = r_o_total;

endmodule

>>> rtl/weighted_sparse_set_tracker.sv
`timescale 1ns / 1ps
// Weighted sparse set tracker: a dense list of variables with positive flip gain.
// Input channel (i_in_valid / o_in_ready): an evaluate item carries a one-based
// variable index and two Q16.16 literal weights; a clear item empties the set.
// Output channel (o_out_valid / i_out_ready): one result per item giving
// membership, the stored weight, the member count and the saturating total.
// Each item passes through lookup, slot read, update and total stages, with
// at most one memory access per port in each, and a done state then moves the
// result into the output register; the block takes a new item only once the
// last one has left the done state.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the following item finishes its update and then
// waits until the output register is free before a further item is taken.
// After reset the membership flag memory is swept, one entry per cycle, over
// all MAX_VARS + 1 entries; o_in_ready stays low during that pass. Count and
// total reset to zero.

module weighted_sparse_set_tracker #(
    parameter int MAX_VARS    = 1024,
    parameter int WEIGHT_BITS = 32,
    localparam int VAR_W = $clog2(MAX_VARS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [VAR_W-1:0]             i_var_index,
    input  logic [WEIGHT_BITS-1:0]       i_unsat_weight,
    input  logic [WEIGHT_BITS-1:0]       i_critical_weight,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_in_set,
    output logic [WEIGHT_BITS-1:0]       o_member_weight,
    output logic [VAR_W-1:0]             o_member_count,
    output logic [wsst_pkg::TOTAL_W-1:0] o_total_weight
);
    import wsst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    wsst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Memories, count, total and output register.
    wsst_dp #(.MAX_VARS(MAX_VARS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_action),
        .i_var_index       (i_var_index),
        .i_unsat_weight    (i_unsat_weight),
        .i_critical_weight (i_critical_weight),
        .o_in_set          (o_in_set),
        .o_member_weight   (o_member_weight),
        .o_member_count    (o_member_count),
        .o_total_weight    (o_total_weight)
    );

`ifndef ASSERT_OFF
    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready while an item is in progress");

    // A result is waiting once a taken item has passed the done state.
    a_result_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##5 o_out_valid)
        else $error("no result after item acceptance");

    // The member count never exceeds the number of variables.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_member_count <= VAR_W'(MAX_VARS)))
        else $error("member count out of range");

    // A non-member reports a zero weight.
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_set) |-> (o_member_weight == '0))
        else $error("weight reported for a non-member");
`endif

endmodule

>>> dv/weighted_sparse_set_tracker_test.sv
`timescale 1ns / 1ps

module weighted_sparse_set_tracker_test;

    import wsst_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_VARS       = 1024;
    localparam int WEIGHT_BITS    = 32;
    localparam int VAR_W          = $clog2(MAX_VARS + 1);
    localparam int FILL_VARS      = 256;
    localparam int RANDOM_PER_RUN = 95;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [WEIGHT_BITS-1:0] W_MAX = {WEIGHT_BITS{1'b1}};

    // One result item as the block reports it.
    typedef struct packed {
        logic                   in_set;
        logic [WEIGHT_BITS-1:0] weight;
        logic [VAR_W-1:0]       count;
        logic [TOTAL_W-1:0]     total;
    } t_set_result;

    // One row of the directed stimulus; fixed rows carry their answer.
    typedef struct {
        logic                   action;
        logic [VAR_W-1:0]       var_index;
        logic [WEIGHT_BITS-1:0] unsat;
        logic [WEIGHT_BITS-1:0] crit;
        bit                     fixed;
        t_set_result            answer;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_action;
    logic [VAR_W-1:0]       i_var_index;
    logic [WEIGHT_BITS-1:0] i_unsat_weight;
    logic [WEIGHT_BITS-1:0] i_critical_weight;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_in_set;
    logic [WEIGHT_BITS-1:0] o_member_weight;
    logic [VAR_W-1:0]       o_member_count;
    logic [TOTAL_W-1:0]     o_total_weight;

    // Shadow copy of the sparse set.
    int                     slot_var [MAX_VARS];
    logic [WEIGHT_BITS-1:0] slot_weight [MAX_VARS];
    int                     var_slot [MAX_VARS+1];
    bit                     var_present [MAX_VARS+1];
    int                     member_total;
    logic [TOTAL_W-1:0]     weight_sum;

    t_set_result pending_results [$];
    t_stim_row   directed_rows [$];
    int          fault_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          stall_pct;

    weighted_sparse_set_tracker #(
        .MAX_VARS    (MAX_VARS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_var_index       (i_var_index),
        .i_unsat_weight    (i_unsat_weight),
        .i_critical_weight (i_critical_weight),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_in_set          (o_in_set),
        .o_member_weight   (o_member_weight),
        .o_member_count    (o_member_count),
        .o_total_weight    (o_total_weight)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Saturating arithmetic on the running total.
    function automatic void total_remove(logic [WEIGHT_BITS-1:0] w);
        weight_sum = (weight_sum >= TOTAL_W'(w)) ? weight_sum - TOTAL_W'(w) : '0;
    endfunction

    function automatic void total_insert(logic [WEIGHT_BITS-1:0] w);
        logic [TOTAL_W:0] wide;
        wide = {1'b0, weight_sum} + (TOTAL_W + 1)'(w);
        weight_sum = wide[TOTAL_W] ? TOTAL_MAX : wide[TOTAL_W-1:0];
    endfunction

    // Applies one item to the shadow set and returns the result it should give.
    function automatic t_set_result apply_to_set(logic act, logic [VAR_W-1:0] vidx,
                                                 logic [WEIGHT_BITS-1:0] unsat,
                                                 logic [WEIGHT_BITS-1:0] crit);
        t_set_result res;
        int          v;
        int          slot;
        int          moved;
        res = '0;
        v   = int'(vidx);
        if (act == ACT_CLEAR) begin
            for (int i = 0; i <= MAX_VARS; i++) begin
                var_present[i] = 1'b0;
            end
            member_total = 0;
            weight_sum   = '0;
        end else if (v >= 1 && v <= MAX_VARS) begin
            if (unsat > crit) begin
                // Positive gain: update in place or append at the end.
                if (var_present[v]) begin
                    slot = var_slot[v];
                    total_remove(slot_weight[slot]);
                    slot_weight[slot] = unsat - crit;
                    total_insert(unsat - crit);
                end else if (member_total < MAX_VARS) begin
                    var_slot[v]                = member_total;
                    slot_var[member_total]     = v;
                    slot_weight[member_total]  = unsat - crit;
                    var_present[v]             = 1'b1;
                    total_insert(unsat - crit);
                    member_total++;
                end
            end else if (var_present[v] && member_total > 0) begin
                // No gain: remove, filling the hole with the last member.
                slot = var_slot[v];
                member_total--;
                total_remove(slot_weight[slot]);
                if (slot != member_total) begin
                    moved              = slot_var[member_total];
                    slot_var[slot]     = moved;
                    slot_weight[slot]  = slot_weight[member_total];
                    var_slot[moved]    = slot;
                end
                var_present[v] = 1'b0;
            end
            if (var_present[v]) begin
                res.in_set = 1'b1;
                res.weight = slot_weight[var_slot[v]];
            end
        end
        res.count = VAR_W'(member_total);
        res.total = weight_sum;
        return res;
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Presents one item from the falling edge and holds it until it is taken.
    task automatic send_item(logic act, logic [VAR_W-1:0] vidx,
                             logic [WEIGHT_BITS-1:0] unsat, logic [WEIGHT_BITS-1:0] crit,
                             bit fixed, t_set_result answer);
        t_set_result predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_action          = act;
        i_var_index       = vidx;
        i_unsat_weight    = unsat;
        i_critical_weight = crit;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted = apply_to_set(act, vidx, unsat, crit);
        pending_results.push_back(fixed ? answer : predicted);
        @(negedge i_clk);
    endtask

    // Random item: mostly evaluations on a small pool so members get removed.
    task automatic send_random_item();
        int                     pick;
        int                     kind;
        logic [VAR_W-1:0]       vidx;
        logic [WEIGHT_BITS-1:0] a;
        logic [WEIGHT_BITS-1:0] b;
        logic [WEIGHT_BITS-1:0] hi;
        logic [WEIGHT_BITS-1:0] lo;
        pick = $urandom_range(99);
        kind = $urandom_range(9);
        a    = $urandom;
        b    = $urandom;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        if (pick < 4) begin
            vidx = ($urandom_range(1) == 0) ? '0 : VAR_W'($urandom_range(MAX_VARS + 1, 2047));
        end else if (pick < 80) begin
            vidx = VAR_W'($urandom_range(1, 16));
        end else begin
            vidx = VAR_W'($urandom_range(1, MAX_VARS));
        end
        if (pick >= 98) begin
            send_item(ACT_CLEAR, VAR_W'($urandom), a, b, 1'b0, '0);
        end else begin
            case (kind)
                0, 1, 2, 3, 4: send_item(ACT_EVAL, vidx, hi, lo, 1'b0, '0);
                5:             send_item(ACT_EVAL, vidx, a, a, 1'b0, '0);
                6, 7:          send_item(ACT_EVAL, vidx, lo, hi, 1'b0, '0);
                8:             send_item(ACT_EVAL, vidx, W_MAX, '0, 1'b0, '0);
                default:       send_item(ACT_EVAL, vidx, '0, W_MAX, 1'b0, '0);
            endcase
        end
    endtask

    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Receiver: random back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_set_result got;
        t_set_result want;
        if (i_rst_n) begin
            got = '{o_in_set, o_member_weight, o_member_count, o_total_weight};
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    note_fault($sformatf("unexpected result in_set=%0d w=%h n=%0d t=%h",
                                         got.in_set, got.weight, got.count, got.total));
                end else begin
                    want = pending_results.pop_front();
                    if (got.in_set !== want.in_set || got.weight !== want.weight ||
                        got.count !== want.count || got.total !== want.total) begin
                        note_fault($sformatf(
                            "mismatch exp in_set=%0d w=%h n=%0d t=%h, got in_set=%0d w=%h n=%0d t=%h",
                            want.in_set, want.weight, want.count, want.total,
                            got.in_set, got.weight, got.count, got.total));
                    end
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        int        send_pcts [4];
        int        stall_pcts [4];
        logic [WEIGHT_BITS-1:0] crit;

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_action          = ACT_EVAL;
        i_var_index       = '0;
        i_unsat_weight    = '0;
        i_critical_weight = '0;
        i_out_ready       = 1'b1;
        fault_count       = 0;
        idle_cycles       = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        member_total      = 0;
        weight_sum        = '0;
        for (int i = 0; i <= MAX_VARS; i++) begin
            var_present[i] = 1'b0;
        end
        send_pcts  = '{0, 51, 0, 21};
        stall_pcts = '{0, 0, 51, 21};

        // Directed rows: answers typed in where they are obvious.
        directed_rows.push_back('{ACT_EVAL, 11'd1, 32'd5, 32'd5, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd0, W_MAX, 32'd0, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1025, W_MAX, 32'd0, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd2047, W_MAX, 32'd0, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1, W_MAX, 32'd0, 1'b1,
                                  '{1'b1, W_MAX, 11'd1, 48'h0000_FFFF_FFFF}});
        directed_rows.push_back('{ACT_EVAL, 11'd1024, 32'h0001_8000, 32'h0000_8000, 1'b1,
                                  '{1'b1, 32'h0001_0000, 11'd2, 48'h0001_0000_FFFF}});
        directed_rows.push_back('{ACT_EVAL, 11'd1, 32'd3, 32'd1, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd2, 32'h7FFF_0000, 32'h0001_0000, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1, 32'd0, W_MAX, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1, 32'd0, 32'd0, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd2, 32'h1234_5678, 32'h1234_5678, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1025, W_MAX, 32'd0, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1024, 32'd1, 32'd0, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd3, W_MAX, 32'hFFFF_FFFE, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd5, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd7, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd3, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd512, W_MAX, 32'd0, 1'b0, '0});
        directed_rows.push_back('{ACT_CLEAR, 11'd2047, W_MAX, W_MAX, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1024, 32'd0, 32'd1, 1'b1, '0});
        directed_rows.push_back('{ACT_EVAL, 11'd1024, 32'd1, 32'd0, 1'b1,
                                  '{1'b1, 32'd1, 11'd1, 48'd1}});
        directed_rows.push_back('{ACT_CLEAR, 11'd0, 32'd0, 32'd0, 1'b1, '0});

        // Reset, then the block sweeps its flag memory before taking items.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.action, row.var_index, row.unsat, row.crit, row.fixed, row.answer);
        end
        wait_for_results();

        // Fill a large part of the set, churn some members, then empty it.
        for (int v = 1; v <= FILL_VARS; v++) begin
            crit = $urandom_range(0, 1000);
            send_item(ACT_EVAL, VAR_W'(v), crit + 1 + $urandom_range(0, 32'h7FFF_FFFF), crit,
                      1'b0, '0);
        end
        send_item(ACT_EVAL, VAR_W'(FILL_VARS / 2), W_MAX, 32'd0, 1'b0, '0);
        send_item(ACT_EVAL, 11'd0, W_MAX, 32'd0, 1'b0, '0);
        for (int k = 0; k < 40; k++) begin
            send_item(ACT_EVAL, VAR_W'($urandom_range(1, FILL_VARS)), 32'd0, $urandom,
                      1'b0, '0);
        end
        send_item(ACT_CLEAR, VAR_W'($urandom), $urandom, $urandom, 1'b0, '0);

        // Random items under each idling pattern; the sender waits for all
        // results to come back between patterns.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            for (int k = 0; k < RANDOM_PER_RUN; k++) begin
                send_random_item();
            end
            wait_for_results();
        end

        i_in_valid = 1'b0;
        stall_pct  = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/wsst_pkg.sv
rtl/wsst_ram.sv
rtl/wsst_ctrl.sv
rtl/wsst_dp.sv
rtl/weighted_sparse_set_tracker.sv
dv/weighted_sparse_set_tracker_test.sv
